// ===== rtl/oat_pkg.sv =====
// ----------------------------------------------------------------------------
// oat_pkg: shared types and codes for the ordered array table
// Request and response payloads, operation and status codes, cell control
// and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package oat_pkg;

	localparam int DATA_W    = 32;
	localparam int OP_W      = 4;
	localparam int IDX_W     = 7;
	localparam int STAT_W    = 2;
	localparam int POS_W     = 6;
	localparam int CNT_W     = 7;
	localparam int DEPTH_DEF = 64;

	// operation codes
	localparam logic [OP_W-1:0] OP_CREATE  = 4'd0;
	localparam logic [OP_W-1:0] OP_INSERT  = 4'd1;
	localparam logic [OP_W-1:0] OP_PUSH    = 4'd2;
	localparam logic [OP_W-1:0] OP_PREPEND = 4'd3;
	localparam logic [OP_W-1:0] OP_DELETE  = 4'd4;
	localparam logic [OP_W-1:0] OP_READ    = 4'd5;
	localparam logic [OP_W-1:0] OP_FIND    = 4'd6;
	localparam logic [OP_W-1:0] OP_REMOVE  = 4'd7;
	localparam logic [OP_W-1:0] OP_POP     = 4'd8;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]          operation;
		logic [IDX_W-1:0]         index;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic signed [DATA_W-1:0] data;
		logic                     found;
		logic [POS_W-1:0]         position;
		logic [CNT_W-1:0]         count;
		logic                     empty_res;
	} rsp_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic shift;  // cells below sel take their right neighbor
		logic push;   // cell at sel takes wdata
		logic clr;    // cells below sel are zeroed
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_FIN
	} st_t;

endpackage

`default_nettype wire

// ===== rtl/ordered_array_table_unit.sv =====
// ----------------------------------------------------------------------------
// ordered_array_table_unit: ordered table of signed 32-bit words
// Chain of DEPTH entry cells with a request sequencer and a response register.
// ----------------------------------------------------------------------------
// The table holds up to DEPTH words in a chain of cells that works as a queue:
// cell 0 is the head, and every pass moves the held entries one by one past
// it, sending kept words to the back, dropping removed ones and adding the
// inserted word at its place, so order is kept. A request with a pass
// (insert, push, prepend, delete, read, find, remove all, pop) rotates the
// chain through its head cell one entry per cycle, with one extra step for
// the added word in the three insert kinds; create, unknown codes and
// rejected requests make no pass.
// One request is in work at a time; a new request is taken while the last
// response still waits in the output register. Errors leave the table as it
// was and report a status code.
`default_nettype none

module ordered_array_table_unit #(
	parameter int DEPTH = oat_pkg::DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire oat_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output oat_pkg::rsp_t      rsp
);
	import oat_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	cell_ctrl_t               ctrl;
	logic [CW-1:0]            sel;
	logic signed [DATA_W-1:0] wdata;
	logic signed [DATA_W-1:0] cell_val [DEPTH];

	// sequencer
	oat_ctrl #(
		.DEPTH (DEPTH),
		.CW    (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.head      (cell_val[0]),
		.ctrl      (ctrl),
		.sel       (sel),
		.wdata     (wdata)
	);

	// cell chain, each cell fed by its right neighbor
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic signed [DATA_W-1:0] right_val;
		if (g == DEPTH - 1) begin : g_last
			assign right_val = '0;
		end else begin : g_mid
			assign right_val = cell_val[g+1];
		end
		oat_cell #(
			.IDX (g),
			.CW  (CW)
		) u_cell (
			.clk   (clk),
			.ctrl  (ctrl),
			.sel   (sel),
			.wdata (wdata),
			.right (right_val),
			.value (cell_val[g])
		);
	end

	// checks on the response contents
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (32'(rsp.count) <= DEPTH))
		else $error("response count above capacity");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.empty_res == (rsp.count == '0)))
		else $error("empty flag disagrees with count");

	a_err_data: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp.status != STAT_OK)) |-> (rsp.data == '0 && !rsp.found))
		else $error("error response carries data");

	a_pos_found: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.found) |-> (rsp.position == '0))
		else $error("position set without a match");

endmodule

`default_nettype wire

// ===== rtl/oat_cell.sv =====
// ----------------------------------------------------------------------------
// oat_cell: one storage cell of the table chain
// Holds one entry; shifts from its right neighbor, loads the write word or
// clears, as the broadcast command and its own position decide.
// ----------------------------------------------------------------------------
`default_nettype none

module oat_cell #(
	parameter int IDX = 0,
	parameter int CW  = 7
) (
	input  wire logic                             clk,
	input  wire oat_pkg::cell_ctrl_t              ctrl,
	input  wire logic [CW-1:0]                    sel,
	input  wire logic signed [oat_pkg::DATA_W-1:0] wdata,
	input  wire logic signed [oat_pkg::DATA_W-1:0] right,
	output logic signed [oat_pkg::DATA_W-1:0]     value
);
	import oat_pkg::*;

	localparam logic [CW-1:0] MY_POS = CW'(IDX);

	logic signed [DATA_W-1:0] value_q;

	// entry register: payload only, no reset
	always_ff @(posedge clk) begin
		if (ctrl.clr) begin
			if (MY_POS < sel) value_q <= '0;
		end else if (ctrl.push && (MY_POS == sel)) begin
			value_q <= wdata;
		end else if (ctrl.shift && (MY_POS < sel)) begin
			value_q <= right;
		end
	end

	assign value = value_q;

endmodule

`default_nettype wire

// ===== rtl/oat_ctrl.sv =====
// ----------------------------------------------------------------------------
// oat_ctrl: request sequencer of the ordered array table
// Checks each request, then walks the stored entries past the head cell,
// rotating, dropping or adding words, and builds the response.
// ----------------------------------------------------------------------------
`default_nettype none

module oat_ctrl #(
	parameter int DEPTH = oat_pkg::DEPTH_DEF,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              req_valid,
	output logic                                   req_ready,
	input  wire oat_pkg::req_t                     req,
	output logic                                   rsp_valid,
	input  wire logic                              rsp_ready,
	output oat_pkg::rsp_t                          rsp,
	input  wire logic signed [oat_pkg::DATA_W-1:0] head,
	output oat_pkg::cell_ctrl_t                    ctrl,
	output logic [CW-1:0]                          sel,
	output logic signed [oat_pkg::DATA_W-1:0]      wdata
);
	import oat_pkg::*;

	localparam int XW = (CW > IDX_W) ? CW : IDX_W;

	st_t state_q, state_d;

	logic                     rsp_valid_q;
	rsp_t                     rsp_q;
	logic [OP_W-1:0]          op_q;
	logic signed [DATA_W-1:0] key_q;
	logic [CW-1:0]            pos_q, j_q, n0_q, len_q, fpos_q;
	logic                     ins_q;
	logic [STAT_W-1:0]        stat_q;
	logic signed [DATA_W-1:0] data_q;
	logic                     found_q;

	logic              acc, load_rsp;
	logic [XW-1:0]     idx_x, len_x, dep_x;
	logic              go_run, do_clr;
	logic [STAT_W-1:0] err;
	logic [CW-1:0]     spos;
	logic              is_ins, shift, push, add, step, done, cap_data, cap_find;
	logic signed [DATA_W-1:0] wd;

	assign idx_x = XW'(req.index);
	assign len_x = XW'(len_q);
	assign dep_x = XW'(DEPTH);

	// request check at accept
	always_comb begin
		go_run = 1'b0;
		do_clr = 1'b0;
		err    = STAT_OK;
		spos   = '0;
		case (req.operation)
			OP_CREATE: begin
				if (idx_x > dep_x) err = STAT_RANGE;
				else do_clr = 1'b1;
			end
			OP_INSERT: begin
				if (idx_x > len_x) err = STAT_RANGE;
				else if (len_x >= dep_x) err = STAT_FULL;
				else begin
					go_run = 1'b1;
					spos   = CW'(idx_x);
				end
			end
			OP_PUSH: begin
				if (len_x >= dep_x) err = STAT_FULL;
				else begin
					go_run = 1'b1;
					spos   = len_q;
				end
			end
			OP_PREPEND: begin
				if (len_x >= dep_x) err = STAT_FULL;
				else go_run = 1'b1;
			end
			OP_DELETE, OP_READ: begin
				if (idx_x >= len_x) err = STAT_RANGE;
				else begin
					go_run = 1'b1;
					spos   = CW'(idx_x);
				end
			end
			OP_FIND, OP_REMOVE: go_run = 1'b1;
			OP_POP: begin
				if (len_q == '0) err = STAT_EMPTY;
				else go_run = 1'b1;
			end
			default: ;
		endcase
	end

	// pass step: rotate or drop the word at the head of the chain, or add one word at the back
	always_comb begin
		is_ins   = (op_q inside {OP_INSERT, OP_PUSH, OP_PREPEND});
		shift    = 1'b0;
		push     = 1'b0;
		wd       = head;
		add      = 1'b0;
		step     = 1'b0;
		done     = 1'b0;
		cap_data = 1'b0;
		cap_find = 1'b0;
		if (state_q == S_RUN) begin
			if (is_ins && !ins_q && (j_q == pos_q)) begin
				push = 1'b1;
				wd   = key_q;
				add  = 1'b1;
			end else if (j_q < n0_q) begin
				step  = 1'b1;
				shift = 1'b1;
				push  = 1'b1;
				case (op_q)
					OP_DELETE: push = (j_q != pos_q);
					OP_REMOVE: push = (head != key_q);
					OP_POP: begin
						push     = (j_q != (n0_q - CW'(1)));
						cap_data = !push;
					end
					OP_READ: cap_data = (j_q == pos_q);
					OP_FIND: cap_find = !found_q && (head == key_q);
					default: ;
				endcase
			end else begin
				done = 1'b1;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (req_valid) state_d = go_run ? S_RUN : S_FIN;
			S_RUN:  if (done) state_d = S_FIN;
			S_FIN:  if (!rsp_valid_q || rsp_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_ready  = (state_q == S_IDLE);
		acc        = req_ready && req_valid;
		load_rsp   = (state_q == S_FIN) && (!rsp_valid_q || rsp_ready);
		ctrl.clr   = acc && do_clr;
		ctrl.shift = shift;
		ctrl.push  = push;
		wdata      = wd;
		if (ctrl.clr) sel = CW'(idx_x);
		else if (shift) sel = len_q - CW'(1);
		else sel = len_q;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			j_q         <= '0;
			ins_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc) begin
				j_q   <= '0;
				ins_q <= 1'b0;
				if (ctrl.clr) len_q <= CW'(idx_x);
			end else if (state_q == S_RUN) begin
				if (add) ins_q <= 1'b1;
				if (step) j_q <= j_q + CW'(1);
				len_q <= len_q - CW'(shift) + CW'(push);
			end
			if (load_rsp) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	// request fields and response build-up
	always_ff @(posedge clk) begin
		if (acc) begin
			op_q    <= req.operation;
			key_q   <= req.value;
			pos_q   <= spos;
			n0_q    <= len_q;
			stat_q  <= err;
			data_q  <= '0;
			found_q <= 1'b0;
			fpos_q  <= '0;
		end else if (state_q == S_RUN) begin
			if (cap_data) data_q <= head;
			if (cap_find) begin
				found_q <= 1'b1;
				fpos_q  <= j_q;
			end
		end
		if (load_rsp) begin
			rsp_q.status    <= stat_q;
			rsp_q.data      <= data_q;
			rsp_q.found     <= found_q;
			rsp_q.position  <= POS_W'(fpos_q);
			rsp_q.count     <= CNT_W'(len_q);
			rsp_q.empty_res <= (len_q == '0);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire
